>>> src/pcr_pkg.sv
// Package for the particle contact resolver: shared types, pipeline sizes
// and the one-bit restoring division step. No dependencies.
`timescale 1ns / 1ps
package pcr_pkg;

  localparam int FRONT_STAGES = 6;
  localparam int DIV_STEPS    = 52;
  localparam int BACK_STAGES  = 3;
  localparam int PIPE_LAT     = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

  localparam logic [16:0] E_ONE = 17'd65536;

  typedef logic [2:0][31:0] vec3_t;
  typedef logic [2:0][15:0] nrm3_t;

  // Item context that travels beside the divider lanes.
  typedef struct packed {
    vec3_t       v0;
    vec3_t       v1;
    nrm3_t       nrm;
    logic [31:0] total;
    logic [51:0] num;
    logic [30:0] pen;
    logic        vel_en;
    logic        pen_en;
  } ctx_t;

  // One lane of the restoring divider: partial remainder, dividend bits
  // still to be brought down, and quotient bits so far.
  typedef struct packed {
    logic [33:0] rem;
    logic [51:0] dvd;
    logic [51:0] quo;
  } div_lane_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [31:0] d);
    div_lane_t   r;
    logic [33:0] t;
    t = {l.rem[32:0], l.dvd[51]};
    r.dvd = {l.dvd[50:0], 1'b0};
    if (t >= {2'b00, d}) begin
      r.rem = t - {2'b00, d};
      r.quo = {l.quo[50:0], 1'b1};
    end else begin
      r.rem = t;
      r.quo = {l.quo[50:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [31:0] sat32(logic signed [39:0] x);
    logic [31:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

>>> src/pcr_front.sv
// Front stages of the contact resolver: closing speed, impulse numerator,
// the wide products and divider setup. Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pcr_pkg::vec3_t     v0,
  input  pcr_pkg::vec3_t     v1,
  input  pcr_pkg::nrm3_t     nrm,
  input  logic [30:0]        im0,
  input  logic [30:0]        im1,
  input  logic [31:0]        pen,
  input  logic [16:0]        restitution,
  output logic               valid_o,
  output pcr_pkg::ctx_t      ctx_o,
  output pcr_pkg::div_lane_t vel_o,
  output pcr_pkg::div_lane_t pen_o
);
  import pcr_pkg::*;

  // Stage 1: captured inputs.
  logic        s1_valid_r;
  vec3_t       s1_v0_r, s1_v1_r;
  nrm3_t       s1_n_r;
  logic [30:0] s1_im0_r, s1_im1_r;
  logic [31:0] s1_pen_r;
  logic [16:0] s1_e_r;
  logic [16:0] e_clamp;

  assign e_clamp = (restitution > E_ONE) ? E_ONE : restitution;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_v0_r  <= v0;
    s1_v1_r  <= v1;
    s1_n_r   <= nrm;
    s1_im0_r <= im0;
    s1_im1_r <= im1;
    s1_pen_r <= pen;
    s1_e_r   <= e_clamp;
  end

  // Stage 2: per-axis products of relative velocity and normal, inverse-mass sum, penetration product.
  logic              s2_valid_r;
  ctx_t              s2_ctx_r, s2_ctx_nxt;
  logic [2:0][48:0]  s2_prod_r, s2_prod_nxt;
  logic [61:0]       s2_pm_r, s2_pm_nxt;
  logic [30:0]       s2_im0_r;
  logic [16:0]       s2_e_r;

  always_comb begin
    logic signed [32:0] diff;
    logic               pen_pos;
    for (int c = 0; c < 3; c++) begin
      diff = $signed({s1_v0_r[c][31], s1_v0_r[c]}) - $signed({s1_v1_r[c][31], s1_v1_r[c]});
      s2_prod_nxt[c] = 49'(diff * $signed(s1_n_r[c]));
    end
    pen_pos = !s1_pen_r[31] && (s1_pen_r != 32'd0);
    s2_ctx_nxt.v0     = s1_v0_r;
    s2_ctx_nxt.v1     = s1_v1_r;
    s2_ctx_nxt.nrm    = s1_n_r;
    s2_ctx_nxt.total  = {1'b0, s1_im0_r} + {1'b0, s1_im1_r};
    s2_ctx_nxt.num    = '0;
    s2_ctx_nxt.pen    = pen_pos ? s1_pen_r[30:0] : 31'd0;
    s2_ctx_nxt.vel_en = 1'b0;
    s2_ctx_nxt.pen_en = pen_pos;
    s2_pm_nxt = {31'd0, s2_ctx_nxt.pen} * {31'd0, s1_im0_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_ctx_r  <= s2_ctx_nxt;
    s2_prod_r <= s2_prod_nxt;
    s2_pm_r   <= s2_pm_nxt;
    s2_im0_r  <= s1_im0_r;
    s2_e_r    <= s1_e_r;
  end

  // Stage 3: closing speed and the enables.
  logic        s3_valid_r;
  ctx_t        s3_ctx_r, s3_ctx_nxt;
  logic [34:0] s3_c16_r;
  logic [61:0] s3_pm_r;
  logic [30:0] s3_im0_r;
  logic [16:0] s3_e_r;
  logic signed [50:0] closing;

  assign closing = 51'($signed(s2_prod_r[0])) + 51'($signed(s2_prod_r[1]))
                 + 51'($signed(s2_prod_r[2]));

  always_comb begin
    s3_ctx_nxt        = s2_ctx_r;
    s3_ctx_nxt.vel_en = (s2_ctx_r.total != 32'd0) && !closing[50] && (closing != 51'sd0);
    s3_ctx_nxt.pen_en = s2_ctx_r.pen_en && (s2_ctx_r.total != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_ctx_r <= s3_ctx_nxt;
    s3_c16_r <= closing[48:14];
    s3_pm_r  <= s2_pm_r;
    s3_im0_r <= s2_im0_r;
    s3_e_r   <= s2_e_r;
  end

  // Stage 4: numerator c16 * (1 + e).
  logic        s4_valid_r;
  ctx_t        s4_ctx_r, s4_ctx_nxt;
  logic [61:0] s4_pm_r;
  logic [30:0] s4_im0_r;
  logic [52:0] num_full;

  assign num_full = {18'd0, s3_c16_r} * ({36'd0, s3_e_r} + 53'd65536);

  always_comb begin
    s4_ctx_nxt     = s3_ctx_r;
    s4_ctx_nxt.num = s3_ctx_r.vel_en ? num_full[51:0] : 52'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_ctx_r <= s4_ctx_nxt;
    s4_pm_r  <= s3_pm_r;
    s4_im0_r <= s3_im0_r;
  end

  // Stage 5: numerator times first inverse mass, as two partial products.
  logic        s5_valid_r;
  ctx_t        s5_ctx_r;
  logic [61:0] s5_pm_r;
  logic [56:0] s5_lo_r, s5_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else begin
      s5_valid_r <= s4_valid_r;
    end
    s5_ctx_r <= s4_ctx_r;
    s5_pm_r  <= s4_pm_r;
    s5_lo_r  <= {31'd0, s4_ctx_r.num[25:0]} * {26'd0, s4_im0_r};
    s5_hi_r  <= {31'd0, s4_ctx_r.num[51:26]} * {26'd0, s4_im0_r};
  end

  // Stage 6: full dividend and divider lane setup.
  logic        s6_valid_r;
  ctx_t        s6_ctx_r;
  div_lane_t   s6_vel_r, s6_vel_nxt, s6_pen_r, s6_pen_nxt;
  logic [82:0] dvd;

  assign dvd = {26'd0, s5_lo_r} + {s5_hi_r, 26'd0};

  always_comb begin
    s6_vel_nxt.rem = {3'd0, dvd[82:52]};
    s6_vel_nxt.dvd = dvd[51:0];
    s6_vel_nxt.quo = '0;
    s6_pen_nxt.rem = {24'd0, s5_pm_r[61:52]};
    s6_pen_nxt.dvd = s5_pm_r[51:0];
    s6_pen_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else begin
      s6_valid_r <= s5_valid_r;
    end
    s6_ctx_r <= s5_ctx_r;
    s6_vel_r <= s6_vel_nxt;
    s6_pen_r <= s6_pen_nxt;
  end

  assign valid_o = s6_valid_r;
  assign ctx_o   = s6_ctx_r;
  assign vel_o   = s6_vel_r;
  assign pen_o   = s6_pen_r;

endmodule

>>> src/pcr_div_stage.sv
// One registered step of the two-lane restoring divider (impulse share and
// displacement share). Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_div_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  pcr_pkg::ctx_t      ctx_i,
  input  pcr_pkg::div_lane_t vel_i,
  input  pcr_pkg::div_lane_t pen_i,
  output logic               valid_o,
  output pcr_pkg::ctx_t      ctx_o,
  output pcr_pkg::div_lane_t vel_o,
  output pcr_pkg::div_lane_t pen_o
);
  import pcr_pkg::*;

  logic      valid_r;
  ctx_t      ctx_r;
  div_lane_t vel_r, pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    ctx_r <= ctx_i;
    vel_r <= div_step(vel_i, ctx_i.total);
    pen_r <= div_step(pen_i, ctx_i.total);
  end

  assign valid_o = valid_r;
  assign ctx_o   = ctx_r;
  assign vel_o   = vel_r;
  assign pen_o   = pen_r;

endmodule

>>> src/pcr_back.sv
// Back stages of the contact resolver: shares for both particles, scaling
// by the normal and saturating sums. Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  pcr_pkg::ctx_t      ctx_i,
  input  pcr_pkg::div_lane_t vel_i,
  input  pcr_pkg::div_lane_t pen_i,
  output logic               valid_o,
  output pcr_pkg::vec3_t     nv0_o,
  output pcr_pkg::vec3_t     nv1_o,
  output pcr_pkg::vec3_t     mv0_o,
  output pcr_pkg::vec3_t     mv1_o
);
  import pcr_pkg::*;

  // Stage A: the second particle's share is the numerator minus the
  // rounded-up first share, so one division serves both.
  logic        a_valid_r;
  ctx_t        a_ctx_r;
  logic [35:0] a_w0_r, a_w1_r;
  logic [30:0] a_p0_r, a_p1_r;
  logic [51:0] q1;
  logic [30:0] p1;

  assign q1 = ctx_i.num - vel_i.quo - {51'd0, (vel_i.rem != 34'd0)};
  assign p1 = ctx_i.pen - pen_i.quo[30:0] - {30'd0, (pen_i.rem != 34'd0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= valid_i;
    end
    a_ctx_r <= ctx_i;
    a_w0_r  <= ctx_i.vel_en ? vel_i.quo[51:16] : 36'd0;
    a_w1_r  <= ctx_i.vel_en ? q1[51:16] : 36'd0;
    a_p0_r  <= ctx_i.pen_en ? pen_i.quo[30:0] : 31'd0;
    a_p1_r  <= ctx_i.pen_en ? p1 : 31'd0;
  end

  // Stage B: magnitudes scaled by |n|, truncated toward zero.
  logic             b_valid_r;
  vec3_t            b_v0_r, b_v1_r;
  logic [2:0]       b_neg_r;
  logic [2:0][37:0] b_d0_r, b_d1_r, b_d0_nxt, b_d1_nxt;
  logic [2:0][32:0] b_m0_r, b_m1_r, b_m0_nxt, b_m1_nxt;
  logic [2:0]       b_neg_nxt;

  always_comb begin
    logic [15:0] an;
    logic [51:0] pv0, pv1;
    logic [46:0] pm0, pm1;
    for (int c = 0; c < 3; c++) begin
      b_neg_nxt[c] = a_ctx_r.nrm[c][15];
      an  = b_neg_nxt[c] ? (16'd0 - a_ctx_r.nrm[c]) : a_ctx_r.nrm[c];
      pv0 = {36'd0, an} * {16'd0, a_w0_r};
      pv1 = {36'd0, an} * {16'd0, a_w1_r};
      pm0 = {31'd0, an} * {16'd0, a_p0_r};
      pm1 = {31'd0, an} * {16'd0, a_p1_r};
      b_d0_nxt[c] = pv0[51:14];
      b_d1_nxt[c] = pv1[51:14];
      b_m0_nxt[c] = pm0[46:14];
      b_m1_nxt[c] = pm1[46:14];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
    b_v0_r  <= a_ctx_r.v0;
    b_v1_r  <= a_ctx_r.v1;
    b_neg_r <= b_neg_nxt;
    b_d0_r  <= b_d0_nxt;
    b_d1_r  <= b_d1_nxt;
    b_m0_r  <= b_m0_nxt;
    b_m1_r  <= b_m1_nxt;
  end

  // Stage C: apply signs, add and saturate into the result registers.
  logic  c_valid_r;
  vec3_t c_nv0_r, c_nv1_r, c_mv0_r, c_mv1_r;
  vec3_t c_nv0_nxt, c_nv1_nxt, c_mv0_nxt, c_mv1_nxt;

  always_comb begin
    logic signed [39:0] ve0, ve1, d0, d1, m0, m1;
    for (int c = 0; c < 3; c++) begin
      ve0 = {{8{b_v0_r[c][31]}}, b_v0_r[c]};
      ve1 = {{8{b_v1_r[c][31]}}, b_v1_r[c]};
      d0  = {2'b00, b_d0_r[c]};
      d1  = {2'b00, b_d1_r[c]};
      m0  = {7'd0, b_m0_r[c]};
      m1  = {7'd0, b_m1_r[c]};
      c_nv0_nxt[c] = sat32(b_neg_r[c] ? (ve0 + d0) : (ve0 - d0));
      c_nv1_nxt[c] = sat32(b_neg_r[c] ? (ve1 - d1) : (ve1 + d1));
      c_mv0_nxt[c] = sat32(b_neg_r[c] ? m0 : (40'sd0 - m0));
      c_mv1_nxt[c] = sat32(b_neg_r[c] ? (40'sd0 - m1) : m1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= b_valid_r;
    end
    c_nv0_r <= c_nv0_nxt;
    c_nv1_r <= c_nv1_nxt;
    c_mv0_r <= c_mv0_nxt;
    c_mv1_r <= c_mv1_nxt;
  end

  assign valid_o = c_valid_r;
  assign nv0_o   = c_nv0_r;
  assign nv1_o   = c_nv1_r;
  assign mv0_o   = c_mv0_r;
  assign mv1_o   = c_mv1_r;

  // With the contact not closing, both velocities must pass unchanged.
  a_hold_vel: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && (a_w0_r == 36'd0) && (a_w1_r == 36'd0)
      |=> ##1 (c_nv0_r == $past(a_ctx_r.v0, 2)) && (c_nv1_r == $past(a_ctx_r.v1, 2)))
    else $error("velocity changed without impulse");

endmodule

>>> src/particle_contact_resolver.sv
// Top level of the particle contact resolver: configuration register, APB
// port, and the front / divider / back pipeline. Depends on pcr_pkg.
//
//   channel  direction  handshake              word
//   in_*     input      start && !busy         one contact
//   out_*    output     out_valid (one cycle)  resolved velocities and moves
//   cfg      APB        psel/penable/pwrite    restitution at address 0
//
// out_valid rises when an accepted contact has passed 6 front stages, 52 one-bit
// divider steps and 3 back stages. A new contact is taken every cycle while
// busy is low; busy is high in reset and for the first cycle after it.
// Reset (rst_n low, synchronous) clears all valid bits and sets restitution
// to one. The receiver cannot stall; results leave as they are produced.
`timescale 1ns / 1ps
module particle_contact_resolver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_first_vel_x,
  input  logic signed [31:0] in_first_vel_y,
  input  logic signed [31:0] in_first_vel_z,
  input  logic signed [31:0] in_second_vel_x,
  input  logic signed [31:0] in_second_vel_y,
  input  logic signed [31:0] in_second_vel_z,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic [30:0]        in_first_inv_mass,
  input  logic [30:0]        in_second_inv_mass,
  input  logic signed [31:0] in_penetration,
  output logic               out_valid,
  output logic signed [31:0] out_first_new_vel_x,
  output logic signed [31:0] out_first_new_vel_y,
  output logic signed [31:0] out_first_new_vel_z,
  output logic signed [31:0] out_second_new_vel_x,
  output logic signed [31:0] out_second_new_vel_y,
  output logic signed [31:0] out_second_new_vel_z,
  output logic signed [31:0] out_first_move_x,
  output logic signed [31:0] out_first_move_y,
  output logic signed [31:0] out_first_move_z,
  output logic signed [31:0] out_second_move_x,
  output logic signed [31:0] out_second_move_y,
  output logic signed [31:0] out_second_move_z,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import pcr_pkg::*;

  logic        busy_r;
  logic [16:0] restitution_r;
  logic        cfg_wr;
  logic        accept;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {15'd0, restitution_r};
  assign busy   = busy_r;
  assign accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b1;
      restitution_r <= E_ONE;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr) begin
        restitution_r <= pwdata[16:0];
      end
    end
  end

  vec3_t     v0, v1, nv0, nv1, mv0, mv1;
  nrm3_t     nrm;
  logic      f_valid;
  ctx_t      f_ctx;
  div_lane_t f_vel, f_pen;

  assign v0  = {in_first_vel_z, in_first_vel_y, in_first_vel_x};
  assign v1  = {in_second_vel_z, in_second_vel_y, in_second_vel_x};
  assign nrm = {in_normal_z, in_normal_y, in_normal_x};

  pcr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .v0          (v0),
    .v1          (v1),
    .nrm         (nrm),
    .im0         (in_first_inv_mass),
    .im1         (in_second_inv_mass),
    .pen         (in_penetration),
    .restitution (restitution_r),
    .valid_o     (f_valid),
    .ctx_o       (f_ctx),
    .vel_o       (f_vel),
    .pen_o       (f_pen)
  );

  logic      d_valid [0:DIV_STEPS];
  ctx_t      d_ctx   [0:DIV_STEPS];
  div_lane_t d_vel   [0:DIV_STEPS];
  div_lane_t d_pen   [0:DIV_STEPS];

  assign d_valid[0] = f_valid;
  assign d_ctx[0]   = f_ctx;
  assign d_vel[0]   = f_vel;
  assign d_pen[0]   = f_pen;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    pcr_div_stage u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (d_valid[i]),
      .ctx_i   (d_ctx[i]),
      .vel_i   (d_vel[i]),
      .pen_i   (d_pen[i]),
      .valid_o (d_valid[i+1]),
      .ctx_o   (d_ctx[i+1]),
      .vel_o   (d_vel[i+1]),
      .pen_o   (d_pen[i+1])
    );
  end

  pcr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (d_valid[DIV_STEPS]),
    .ctx_i   (d_ctx[DIV_STEPS]),
    .vel_i   (d_vel[DIV_STEPS]),
    .pen_i   (d_pen[DIV_STEPS]),
    .valid_o (out_valid),
    .nv0_o   (nv0),
    .nv1_o   (nv1),
    .mv0_o   (mv0),
    .mv1_o   (mv1)
  );

  assign out_first_new_vel_x  = nv0[0];
  assign out_first_new_vel_y  = nv0[1];
  assign out_first_new_vel_z  = nv0[2];
  assign out_second_new_vel_x = nv1[0];
  assign out_second_new_vel_y = nv1[1];
  assign out_second_new_vel_z = nv1[2];
  assign out_first_move_x     = mv0[0];
  assign out_first_move_y     = mv0[1];
  assign out_first_move_z     = mv0[2];
  assign out_second_move_x    = mv1[0];
  assign out_second_move_y    = mv1[1];
  assign out_second_move_z    = mv1[2];

  // Every word out matches exactly one accepted word in, and every word in gives one out.
  a_out_has_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_LAT))
    else $error("result without a matching contact");

  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("contact lost in the pipeline");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> restitution_r == $past(pwdata[16:0]))
    else $error("restitution write not taken");

endmodule

>>> tb/particle_contact_resolver_test.sv
// Self-checking testbench for particle_contact_resolver: random and directed
// contacts against an in-bench fixed-point predictor. Depends on pcr_pkg and the RTL.
`timescale 1ns / 1ps
module particle_contact_resolver_test;
  import pcr_pkg::*;

  localparam logic [2:0] ADDR_RESTITUTION = 3'd0;
  localparam int         DRAIN_CYCLES     = PIPE_LAT + 10;

  typedef struct packed {
    logic [2:0][31:0] v0;
    logic [2:0][31:0] v1;
    logic [2:0][15:0] nrm;
    logic [30:0]      im0;
    logic [30:0]      im1;
    logic [31:0]      pen;
  } contact_t;

  typedef struct packed {
    logic [2:0][31:0] nv0;
    logic [2:0][31:0] nv1;
    logic [2:0][31:0] mv0;
    logic [2:0][31:0] mv1;
  } resolved_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0][31:0] drv_v0 = '0;
  logic [2:0][31:0] drv_v1 = '0;
  logic [2:0][15:0] drv_nrm = '0;
  logic [30:0] drv_im0 = '0;
  logic [30:0] drv_im1 = '0;
  logic [31:0] drv_pen = '0;
  logic out_valid;
  resolved_t got;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  contact_t  contact_q[$];
  resolved_t resolved_q[$];
  logic [16:0] restitution_reg = E_ONE;
  bit hold_off = 1'b0;
  bit quiet = 1'b0;
  int gap = 0;
  int errors = 0;
  int accepted = 0;
  int results = 0;
  int closing_seen = 0;

  particle_contact_resolver u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_vel_x(drv_v0[0]), .in_first_vel_y(drv_v0[1]), .in_first_vel_z(drv_v0[2]),
    .in_second_vel_x(drv_v1[0]), .in_second_vel_y(drv_v1[1]),
    .in_second_vel_z(drv_v1[2]),
    .in_normal_x(drv_nrm[0]), .in_normal_y(drv_nrm[1]), .in_normal_z(drv_nrm[2]),
    .in_first_inv_mass(drv_im0), .in_second_inv_mass(drv_im1),
    .in_penetration(drv_pen),
    .out_valid(out_valid),
    .out_first_new_vel_x(got.nv0[0]), .out_first_new_vel_y(got.nv0[1]),
    .out_first_new_vel_z(got.nv0[2]),
    .out_second_new_vel_x(got.nv1[0]), .out_second_new_vel_y(got.nv1[1]),
    .out_second_new_vel_z(got.nv1[2]),
    .out_first_move_x(got.mv0[0]), .out_first_move_y(got.mv0[1]),
    .out_first_move_z(got.mv0[2]),
    .out_second_move_x(got.mv1[0]), .out_second_move_y(got.mv1[1]),
    .out_second_move_z(got.mv1[2]),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Normal component times a magnitude, truncated toward zero, back in Q.16.
  function automatic longint along_normal(logic signed [15:0] n, longint unsigned mag);
    longint unsigned an;
    longint unsigned p;
    an = (n < 0) ? longint'(-n) : longint'(n);
    p = (an * mag) >> 14;
    return (n < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic resolved_t resolve_contact(contact_t c, logic [16:0] e_reg);
    resolved_t r;
    longint closing;
    longint nv0[3], nv1[3], mv0[3], mv1[3];
    longint unsigned total, e, num, w0, w1, p0, p1;
    logic [95:0] wide;
    closing = 0;
    for (int i = 0; i < 3; i++) begin
      closing += (longint'($signed(c.v0[i])) - longint'($signed(c.v1[i])))
                 * longint'($signed(c.nrm[i]));
      nv0[i] = $signed(c.v0[i]);
      nv1[i] = $signed(c.v1[i]);
      mv0[i] = 0;
      mv1[i] = 0;
    end
    total = longint'(c.im0) + longint'(c.im1);
    e = (e_reg > E_ONE) ? 65536 : e_reg;
    if (total != 0) begin
      if (closing > 0) begin
        num = (longint'(closing) >>> 14) * (65536 + e);
        wide = 96'(num) * 96'(c.im0);
        w0 = 64'(wide / 96'(total)) >> 16;
        wide = 96'(num) * 96'(c.im1);
        w1 = 64'(wide / 96'(total)) >> 16;
        for (int i = 0; i < 3; i++) begin
          nv0[i] -= along_normal(c.nrm[i], w0);
          nv1[i] += along_normal(c.nrm[i], w1);
        end
      end
      if ($signed(c.pen) > 0) begin
        p0 = (longint'(c.pen) * longint'(c.im0)) / total;
        p1 = (longint'(c.pen) * longint'(c.im1)) / total;
        for (int i = 0; i < 3; i++) begin
          mv0[i] = -along_normal(c.nrm[i], p0);
          mv1[i] = along_normal(c.nrm[i], p1);
        end
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.nv0[i] = clamp32(nv0[i]);
      r.nv1[i] = clamp32(nv1[i]);
      r.mv0[i] = clamp32(mv0[i]);
      r.mv1[i] = clamp32(mv1[i]);
    end
    return r;
  endfunction

  // Sender: one contact per accepting edge, with bursts of idle cycles.
  always @(posedge clk) begin
    contact_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (contact_q.size() > 0 && !hold_off) begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        gap <= $urandom_range(1, 7) - 1;
        start <= 1'b0;
      end else begin
        it = contact_q.pop_front();
        drv_v0 <= it.v0;
        drv_v1 <= it.v1;
        drv_nrm <= it.nrm;
        drv_im0 <= it.im0;
        drv_im1 <= it.im1;
        drv_pen <= it.pen;
        start <= 1'b1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on acceptance, compare each result word in order.
  always @(posedge clk) begin
    contact_t c;
    resolved_t want;
    string group[4];
    group = '{"first_new_vel", "second_new_vel", "first_move", "second_move"};
    if (rst_n && out_valid) begin
      results++;
      if (resolved_q.size() == 0) begin
        $error("result word with no contact outstanding");
        errors++;
      end else begin
        want = resolved_q.pop_front();
        for (int g = 0; g < 4; g++) begin
          for (int i = 0; i < 3; i++) begin
            if (want[(3 - g) * 96 + i * 32 +: 32] != got[(3 - g) * 96 + i * 32 +: 32]) begin
              $error("%s_%s expected %0d actual %0d", group[g], i == 0 ? "x" : i == 1 ? "y" : "z",
                     $signed(want[(3 - g) * 96 + i * 32 +: 32]),
                     $signed(got[(3 - g) * 96 + i * 32 +: 32]));
              errors++;
            end
          end
        end
      end
    end
    if (rst_n && start && !busy) begin
      c.v0 = drv_v0;
      c.v1 = drv_v1;
      c.nrm = drv_nrm;
      c.im0 = drv_im0;
      c.im1 = drv_im1;
      c.pen = drv_pen;
      want = resolve_contact(c, restitution_reg);
      resolved_q.push_back(want);
      accepted++;
      closing_seen += (want.nv0 != c.v0);
    end
  end

  function automatic logic [31:0] rand_vel(bit wild);
    if (wild) return $urandom;
    return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
  endfunction

  function automatic contact_t rand_contact();
    contact_t c;
    bit wild;
    wild = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < 3; i++) begin
      c.v0[i] = rand_vel(wild);
      c.v1[i] = rand_vel(wild);
      c.nrm[i] = wild ? 16'($urandom) : 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    case ($urandom_range(0, 5))
      0: begin c.im0 = '0; c.im1 = 31'($urandom_range(1, 1 << 20)); end
      1: begin c.im0 = 31'($urandom_range(1, 1 << 20)); c.im1 = '0; c.v1 = '0; end
      2: begin c.im0 = 31'($urandom); c.im1 = 31'($urandom); end
      default: begin
        c.im0 = 31'($urandom_range(0, 1 << 18));
        c.im1 = 31'($urandom_range(0, 1 << 18));
      end
    endcase
    c.pen = wild ? $urandom : 32'($signed($urandom_range(0, 1 << 20)) - (1 << 18));
    return c;
  endfunction

  function automatic contact_t head_on(logic [31:0] vx, logic [31:0] ux, logic [15:0] nx,
                                       logic [30:0] m0, logic [30:0] m1, logic [31:0] pen);
    contact_t c;
    c = '0;
    c.v0[0] = vx;
    c.v1[0] = ux;
    c.nrm[0] = nx;
    c.im0 = m0;
    c.im1 = m1;
    c.pen = pen;
    return c;
  endfunction

  task automatic wait_idle();
    while (contact_q.size() > 0 || start || resolved_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_restitution(logic [16:0] value);
    hold_off = 1'b1;
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_RESTITUTION;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    restitution_reg = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    hold_off = 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) contact_q.push_back(rand_contact());
    while (contact_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    contact_t c;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed contacts at reset restitution of one.
    contact_q.push_back(head_on(32'h0001_0000, 32'hFFFF_0000, 16'sd16384,
                                31'h1_0000, 31'h1_0000, 32'h0000_8000));
    contact_q.push_back(head_on(32'h0001_0000, 32'hFFFF_0000, 16'sd16384, '0, '0,
                                32'h0001_0000));
    contact_q.push_back(head_on(32'hFFFF_0000, 32'h0001_0000, 16'sd16384,
                                31'h1_0000, 31'h1_0000, 32'hFFFF_0000));
    contact_q.push_back(head_on(32'h0002_0000, '0, 16'sd16384, 31'h1_0000, '0,
                                32'h0000_4000));
    contact_q.push_back(head_on(32'h7FFF_FFFF, 32'h8000_0000, 16'sd16384,
                                31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF));
    contact_q.push_back(head_on(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000,
                                31'h7FFF_FFFF, 31'h1, 32'h8000_0000));
    contact_q.push_back(head_on(32'h7FFF_FFFF, 32'h8000_0000, 16'sd32767,
                                31'h1, 31'h7FFF_FFFF, 32'h7FFF_FFFF));
    contact_q.push_back(head_on('0, '0, '0, 31'h1_0000, 31'h1_0000, 32'h0001_0000));
    c = head_on(32'h0003_0000, 32'hFFFD_0000, 16'sd11585, 31'h2_0000, 31'h8000, 32'h1_0000);
    c.v0[1] = 32'h0001_0000;
    c.nrm[1] = -16'sd11585;
    c.nrm[2] = 16'sd100;
    contact_q.push_back(c);
    c.nrm = {3{16'h8000}};
    c.v0 = {3{32'h8000_0000}};
    c.v1 = {3{32'h7FFF_FFFF}};
    contact_q.push_back(c);
    random_phase(120);

    write_restitution(17'd0);
    contact_q.push_back(head_on(32'h0001_0000, 32'hFFFF_0000, 16'sd16384,
                                31'h1_0000, 31'h1_0000, '0));
    random_phase(120);
    write_restitution(17'h1FFFF);
    random_phase(120);
    write_restitution(17'd65537);
    random_phase(60);
    write_restitution(17'($urandom_range(1, 65535)));
    random_phase(140);
    write_restitution(E_ONE);
    quiet = 1'b1;
    random_phase(140);

    hold_off = 1'b1;
    wait_idle();
    $display("%0d contacts checked over six restitution settings, %0d with a velocity change.",
             accepted, closing_seen);
    if (errors == 0 && results == accepted) begin
      $display("particle_contact_resolver test passed");
    end else begin
      $display("particle_contact_resolver test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("particle_contact_resolver test failed");
    $finish;
  end

endmodule
